>>> rtl/knn_pkg.sv
// Package for the k-nearest-neighbor vote classifier.
// Holds field widths, register indexes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package knn_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_NEIGHBOURS_DEF = 16;
  localparam int DIST_BITS_DEF      = 32;

  // Fixed field widths.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CLS_W     = 4;
  localparam int PRED_W    = 5;
  localparam int MATCH_W   = 16;

  // Class indices are four bits wide, so at most sixteen classes exist.
  localparam int MAX_CLASSES = 16;

  // Register reset values.
  localparam logic [CFG_W-1:0] NUM_NEIGHBOURS_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0] MIN_VOTES_RST      = CFG_W'(0);
  localparam logic [CFG_W-1:0] NUM_CLASSES_RST    = CFG_W'(2);

  localparam logic [MATCH_W-1:0] MATCH_MAX = {MATCH_W{1'b1}};
  localparam logic [PRED_W-1:0]  PRED_NONE = {PRED_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_NEIGHBOURS = 2'd0,
    REG_MIN_VOTES      = 2'd1,
    REG_NUM_CLASSES    = 2'd2,
    REG_COUNT_MODE     = 2'd3
  } knn_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_RESULT
  } knn_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;     // accept one neighbor word
    logic idx_clr;    // restart the slot or class index
    logic count_step; // tally the vote of one slot
    logic scan_step;  // compare one class against the leader
    logic finish;     // close the query, load the result register
  } knn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_done; // index is on the last kept slot
    logic scan_done;  // index is on the last class in use
    logic out_free;   // result register can take a new word
  } knn_sts_t;

endpackage

>>> rtl/knn_if.sv
// Channel interfaces of the k-nearest-neighbor vote classifier: neighbor
// input, result output and configuration write. Depends on knn_pkg.
interface knn_in_if
  import knn_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic [CLS_W-1:0]     neighbour_class;
  logic                 is_self;
  logic                 last_neighbour;
  logic [CLS_W-1:0]     true_class;
  logic                 last_query;

  modport source (output valid, distance, neighbour_class, is_self, last_neighbour,
                  true_class, last_query, input ready);
  modport sink   (input valid, distance, neighbour_class, is_self, last_neighbour,
                  true_class, last_query, output ready);
endinterface

interface knn_out_if
  import knn_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [PRED_W-1:0]  predicted_class;
  logic [MATCH_W-1:0]        match_count;
  logic                      is_count;

  modport source (output valid, predicted_class, match_count, is_count, input ready);
  modport sink   (input valid, predicted_class, match_count, is_count, output ready);
endinterface

interface knn_cfg_if
  import knn_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/knn_ctrl.sv
// Controller of the k-nearest-neighbor vote classifier: sequences the insert,
// vote tally, class scan and result phases. Depends on knn_pkg.
module knn_ctrl
  import knn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_neighbour,
  output logic     in_ready,
  input  knn_sts_t sts,
  output knn_cmd_t cmd
);

  knn_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last_neighbour) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (sts.count_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.insert  = in_valid;
        cmd.idx_clr = 1'b1;
      end
      ST_COUNT: begin
        cmd.count_step = 1'b1;
        cmd.idx_clr    = sts.count_done;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_RESULT: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/knn_dp.sv
// Datapath of the k-nearest-neighbor vote classifier: configuration
// registers, sorted neighbor slots, vote counters, leader scan, match total
// and the result register. Depends on knn_pkg.
module knn_dp
  import knn_pkg::*;
#(
  parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int DIST_BITS      = DIST_BITS_DEF
)(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // neighbor word
  input  logic [DIST_BITS-1:0]     in_distance,
  input  logic [CLS_W-1:0]         in_neighbour_class,
  input  logic                     in_is_self,
  input  logic                     in_last_neighbour,
  input  logic [CLS_W-1:0]         in_true_class,
  input  logic                     in_last_query,
  // result word
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PRED_W-1:0] out_predicted_class,
  output logic [MATCH_W-1:0]       out_match_count,
  output logic                     out_is_count,
  // controller
  input  knn_cmd_t                 cmd,
  output knn_sts_t                 sts
);

  localparam int KW   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int CW   = (KW > CFG_W) ? KW : CFG_W;
  localparam int VW   = KW;
  localparam int SIW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  // Configuration registers.
  logic [CFG_W-1:0] num_neighbours_r, min_votes_r, num_classes_r;
  logic             count_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_neighbours_r <= NUM_NEIGHBOURS_RST;
      min_votes_r      <= MIN_VOTES_RST;
      num_classes_r    <= NUM_CLASSES_RST;
      count_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (knn_reg_t'(cfg_index))
        REG_NUM_NEIGHBOURS: num_neighbours_r <= cfg_data;
        REG_MIN_VOTES:      min_votes_r      <= cfg_data;
        REG_NUM_CLASSES:    num_classes_r    <= cfg_data;
        REG_COUNT_MODE:     count_mode_r     <= cfg_data[0];
        default:            count_mode_r     <= count_mode_r;
      endcase
    end
  end

  // Effective k and class count after clamping.
  logic [CW-1:0] eff_k, eff_nc;

  always_comb begin
    if (num_neighbours_r == '0) begin
      eff_k = CW'(1);
    end else if (CW'(num_neighbours_r) > CW'(MAX_NEIGHBOURS)) begin
      eff_k = CW'(MAX_NEIGHBOURS);
    end else begin
      eff_k = CW'(num_neighbours_r);
    end
    if (num_classes_r == '0) begin
      eff_nc = CW'(1);
    end else if (CW'(num_classes_r) > CW'(MAX_CLASSES)) begin
      eff_nc = CW'(MAX_CLASSES);
    end else begin
      eff_nc = CW'(num_classes_r);
    end
  end

  // Neighbor slots, worst distance in slot 0.
  logic [DIST_BITS-1:0] slot_dist_r  [MAX_NEIGHBOURS];
  logic [CLS_W-1:0]     slot_class_r [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0] slot_filled_r;

  // A slot takes part in the insertion while the new distance beats it and
  // every slot before it; the last such slot receives the new entry.
  logic [MAX_NEIGHBOURS-1:0] beats, go, go_up;

  always_comb begin
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      if (i == 0) begin
        beats[i] = in_distance < slot_dist_r[i];
      end else begin
        beats[i] = (CW'(i) < eff_k) && (in_distance < slot_dist_r[i]);
      end
    end
    go[0] = beats[0];
    for (int i = 1; i < MAX_NEIGHBOURS; i++) begin
      go[i] = go[i-1] & beats[i];
    end
  end

  logic do_insert;
  assign do_insert = cmd.insert && !in_is_self;

  for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_slot
    logic [DIST_BITS-1:0] up_dist;
    logic [CLS_W-1:0]     up_class;
    logic                 up_filled;

    if (g < MAX_NEIGHBOURS - 1) begin : g_up
      assign go_up[g]  = go[g+1];
      assign up_dist   = slot_dist_r[g+1];
      assign up_class  = slot_class_r[g+1];
      assign up_filled = slot_filled_r[g+1];
    end else begin : g_top
      assign go_up[g]  = 1'b0;
      assign up_dist   = DIST_INF;
      assign up_class  = '0;
      assign up_filled = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.finish) begin
        slot_dist_r[g]   <= DIST_INF;
        slot_class_r[g]  <= '0;
        slot_filled_r[g] <= 1'b0;
      end else if (do_insert && go[g]) begin
        if (go_up[g]) begin
          slot_dist_r[g]   <= up_dist;
          slot_class_r[g]  <= up_class;
          slot_filled_r[g] <= up_filled;
        end else begin
          slot_dist_r[g]   <= in_distance;
          slot_class_r[g]  <= in_neighbour_class;
          slot_filled_r[g] <= 1'b1;
        end
      end
    end
  end

  // End-of-query fields, kept until the result is formed.
  logic [CLS_W-1:0] true_class_r;
  logic             last_query_r;

  always_ff @(posedge clk) begin
    if (cmd.insert && in_last_neighbour) begin
      true_class_r <= in_true_class;
      last_query_r <= in_last_query;
    end
  end

  // Shared index over slots, then over classes.
  logic [CW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.count_step || cmd.scan_step) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  assign sts.count_done = idx_r == eff_k - CW'(1);
  assign sts.scan_done  = idx_r == eff_nc - CW'(1);

  // Vote tally, one slot per cycle.
  logic [VW-1:0]    vote_r [MAX_CLASSES];
  logic [CLS_W-1:0] cur_class;
  logic             cur_votes;

  assign cur_class = slot_class_r[idx_r[SIW-1:0]];
  assign cur_votes = slot_filled_r[idx_r[SIW-1:0]] && (CW'(cur_class) < eff_nc);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        vote_r[c] <= '0;
      end
    end else if (cmd.count_step && cur_votes) begin
      vote_r[cur_class] <= vote_r[cur_class] + VW'(1);
    end
  end

  // Leader scan, one class per cycle; an equal count makes it undecided.
  logic [CLS_W-1:0] lead_r;
  logic [VW-1:0]    lead_votes_r;
  logic             decided_r;
  logic [VW-1:0]    scan_votes;

  assign scan_votes = vote_r[idx_r[CLS_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (idx_r == '0) begin
        lead_r       <= '0;
        lead_votes_r <= scan_votes;
        decided_r    <= 1'b1;
      end else if (scan_votes > lead_votes_r) begin
        lead_r       <= idx_r[CLS_W-1:0];
        lead_votes_r <= scan_votes;
        decided_r    <= 1'b1;
      end else if (scan_votes == lead_votes_r) begin
        decided_r    <= 1'b0;
      end
    end
  end

  // Result forming and the saturating match total.
  logic               pred_ok, hit, produce;
  logic [PRED_W-1:0]  pred;
  logic [MATCH_W-1:0] matches_r, matches_inc;

  assign pred_ok     = decided_r && (CW'(lead_votes_r) >= CW'(min_votes_r));
  assign pred        = pred_ok ? PRED_W'(lead_r) : PRED_NONE;
  assign hit         = pred_ok && (lead_r == true_class_r) && (matches_r != MATCH_MAX);
  assign matches_inc = matches_r + MATCH_W'(hit);
  assign produce     = !count_mode_r || last_query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_r <= '0;
    end else if (cmd.finish) begin
      if (last_query_r) begin
        matches_r <= '0;
      end else if (count_mode_r) begin
        matches_r <= matches_inc;
      end
    end
  end

  // Result register; it frees up in the cycle the receiver takes the word.
  logic                     out_valid_r;
  logic signed [PRED_W-1:0] out_pred_r;
  logic [MATCH_W-1:0]       out_match_r;
  logic                     out_is_count_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && produce) begin
      if (count_mode_r) begin
        out_pred_r     <= '0;
        out_match_r    <= matches_inc;
        out_is_count_r <= 1'b1;
      end else begin
        out_pred_r     <= pred;
        out_match_r    <= '0;
        out_is_count_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_pred_r;
  assign out_match_count     = out_match_r;
  assign out_is_count        = out_is_count_r;

endmodule

>>> rtl/knn_vote_classifier.sv
// Top level of the k-nearest-neighbor vote classifier.
// Joins the controller and the datapath to the channel interfaces.
// Depends on knn_pkg, knn_if, knn_ctrl and knn_dp.
//
// Usage:
//   in_ch carries one training neighbor of the current query per word. A
//   word without the end-of-query mark is taken as soon as it is valid: the distance
//   is compared against all kept slots at once and shifted into place.
//   The word with last_neighbour starts the vote: the tally takes one slot
//   per cycle, then the scan takes one class in use per cycle to find the
//   leader, then the result register is loaded once it is free. in_ch.ready
//   is low from the end-of-query word until the result register is loaded,
//   and the result is valid once the register is loaded.
//   out_ch carries one prediction per query, or in count mode only the
//   match total after the last query. The result register lets the next
//   query stream in while a result waits; if the receiver still holds the
//   previous word at the end of the next query, the block waits there.
//   cfg_ch is always ready and writes a register on every valid word; write it
//   only between queries. Reset restores the register defaults, empties
//   the slots and vote counters and clears the match total.
module knn_vote_classifier
  import knn_pkg::*;
#(
  parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int DIST_BITS      = DIST_BITS_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  knn_in_if.sink    in_ch,
  knn_out_if.source out_ch,
  knn_cfg_if.sink   cfg_ch
);

  knn_cmd_t cmd;
  knn_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  knn_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_last_neighbour (in_ch.last_neighbour),
    .in_ready          (in_ch.ready),
    .sts               (sts),
    .cmd               (cmd)
  );

  knn_dp #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .DIST_BITS      (DIST_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .in_distance         (in_ch.distance),
    .in_neighbour_class  (in_ch.neighbour_class),
    .in_is_self          (in_ch.is_self),
    .in_last_neighbour   (in_ch.last_neighbour),
    .in_true_class       (in_ch.true_class),
    .in_last_query       (in_ch.last_query),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_predicted_class (out_ch.predicted_class),
    .out_match_count     (out_ch.match_count),
    .out_is_count        (out_ch.is_count),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  // The end-of-query word blocks further input while the vote runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_neighbour) |=> !in_ch.ready)
    else $error("input accepted during the vote phase");

  // A query closes only when the result register can take the word.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("query closed while the result register was busy");

  // A result appears only right after a query closes.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("result raised without a closed query");

endmodule

>>> sim/tb_knn_vote_classifier.sv
// Self-checking testbench for knn_vote_classifier: drives neighbor words and
// register writes, predicts every vote result and checks it as it arrives.
// Depends on knn_pkg, knn_if and the knn_vote_classifier RTL.
module tb_knn_vote_classifier;
  import knn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  // The drain wait is sized from the largest k and class count to outlast the longest vote pass.
  localparam int          DRAIN_CYCLES = 2 * (MAX_NEIGHBOURS_DEF + MAX_CLASSES + 2);
  localparam int          COUNT_RUN_QUERIES = 40;

  typedef logic [DIST_BITS_DEF-1:0] dist_t;

  typedef struct {
    dist_t            distance;
    logic [CLS_W-1:0] neighbour_class;
    logic             is_self;
    logic             last_neighbour;
    logic [CLS_W-1:0] true_class;
    logic             last_query;
  } nb_word_t;

  typedef struct {
    logic signed [PRED_W-1:0] predicted_class;
    logic [MATCH_W-1:0]       match_count;
    logic                     is_count;
  } vote_result_t;

  logic clk = 1'b0;
  logic rst_n;

  knn_in_if #(.DIST_BITS(DIST_BITS_DEF)) in_ch();
  knn_out_if out_ch();
  knn_cfg_if cfg_ch();

  knn_vote_classifier DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the neighbor list, the match total and the registers.
  dist_t              kept_dist [MAX_NEIGHBOURS_DEF];
  logic [CLS_W-1:0]   kept_cls  [MAX_NEIGHBOURS_DEF];
  bit                 kept_full [MAX_NEIGHBOURS_DEF];
  logic [MATCH_W-1:0] match_total;
  int unsigned        k_cfg;
  int unsigned        minv_cfg;
  int unsigned        ncls_cfg;
  bit                 count_cfg;

  vote_result_t pending_votes[$];
  int           fail_count = 0;
  bit           idle_on = 1'b1;
  int           stall_left = 0;
  int unsigned  cycle_count = 0;

  function automatic void clear_kept();
    int i;
    for (i = 0; i < MAX_NEIGHBOURS_DEF; i++) begin
      kept_dist[i] = '1;
      kept_cls[i]  = '0;
      kept_full[i] = 1'b0;
    end
  endfunction

  function automatic int active_k();
    if (k_cfg < 1) return 1;
    if (k_cfg > MAX_NEIGHBOURS_DEF) return MAX_NEIGHBOURS_DEF;
    return k_cfg;
  endfunction

  function automatic int active_classes();
    if (ncls_cfg < 1) return 1;
    if (ncls_cfg > MAX_CLASSES) return MAX_CLASSES;
    return ncls_cfg;
  endfunction

  // Sorted insert, worst first: only a strictly smaller distance gets in.
  function automatic void insert_neighbour(dist_t d, logic [CLS_W-1:0] c);
    int k;
    int pos;
    int i;
    k = active_k();
    if (!(d < kept_dist[0])) return;
    pos = 1;
    while (pos < k && d < kept_dist[pos]) pos++;
    for (i = 1; i < pos; i++) begin
      kept_dist[i-1] = kept_dist[i];
      kept_cls[i-1]  = kept_cls[i];
      kept_full[i-1] = kept_full[i];
    end
    kept_dist[pos-1] = d;
    kept_cls[pos-1]  = c;
    kept_full[pos-1] = 1'b1;
  endfunction

  // Majority vote; a tie with the current leader leaves the vote undecided.
  function automatic logic signed [PRED_W-1:0] tally_winner();
    int tally [MAX_CLASSES];
    int k;
    int nc;
    int lead;
    int i;
    bit decided;
    k  = active_k();
    nc = active_classes();
    for (i = 0; i < MAX_CLASSES; i++) tally[i] = 0;
    for (i = 0; i < k; i++) begin
      if (kept_full[i] && int'(kept_cls[i]) < nc) tally[kept_cls[i]]++;
    end
    lead    = 0;
    decided = 1'b1;
    for (i = 1; i < nc; i++) begin
      if (tally[i] > tally[lead]) begin
        lead    = i;
        decided = 1'b1;
      end else if (tally[i] == tally[lead]) begin
        decided = 1'b0;
      end
    end
    if (decided && tally[lead] >= int'(minv_cfg)) return PRED_W'(lead);
    return PRED_NONE;
  endfunction

  // Works out the result, if any, that one accepted word causes.
  function automatic void classify_word(nb_word_t w);
    logic signed [PRED_W-1:0] pred;
    vote_result_t             r;
    if (!w.is_self) insert_neighbour(w.distance, w.neighbour_class);
    if (!w.last_neighbour) return;
    pred = tally_winner();
    if (count_cfg) begin
      if (!pred[PRED_W-1] && pred[CLS_W-1:0] == w.true_class && match_total != MATCH_MAX)
        match_total++;
      if (w.last_query) begin
        r.predicted_class = '0;
        r.match_count     = match_total;
        r.is_count        = 1'b1;
        pending_votes.push_back(r);
        match_total = '0;
      end
    end else begin
      r.predicted_class = pred;
      r.match_count     = '0;
      r.is_count        = 1'b0;
      pending_votes.push_back(r);
      if (w.last_query) match_total = '0;
    end
    clear_kept();
  endfunction

  function automatic void apply_reg(knn_reg_t idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_NUM_NEIGHBOURS: k_cfg = val;
      REG_MIN_VOTES:      minv_cfg = val;
      REG_NUM_CLASSES:    ncls_cfg = val;
      REG_COUNT_MODE:     count_cfg = val[0];
      default: ;
    endcase
  endfunction

  function automatic nb_word_t mk_word(dist_t d, int c, bit self_flag, bit last_nb,
                                       int truth, bit last_q);
    nb_word_t w;
    w.distance        = d;
    w.neighbour_class = CLS_W'(c);
    w.is_self         = self_flag;
    w.last_neighbour  = last_nb;
    w.true_class      = CLS_W'(truth);
    w.last_query      = last_q;
    return w;
  endfunction

  // Sends one neighbor word. Called at a falling edge, returns at one; valid
  // stays high so that back-to-back words need no second assignment.
  task automatic send_word(nb_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.distance        <= w.distance;
    in_ch.neighbour_class <= w.neighbour_class;
    in_ch.is_self         <= w.is_self;
    in_ch.last_neighbour  <= w.last_neighbour;
    in_ch.true_class      <= w.true_class;
    in_ch.last_query      <= w.last_query;
    do @(posedge clk); while (!in_ch.ready);
    classify_word(w);
    @(negedge clk);
  endtask

  // Lets every pending result drain and the vote pass settle.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_votes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_config(logic [CFG_W-1:0] k, logic [CFG_W-1:0] mv,
                            logic [CFG_W-1:0] nc, logic cm);
    knn_reg_t         idx;
    logic [CFG_W-1:0] val;
    int               r;
    wait_quiet();
    for (r = 0; r < 4; r++) begin
      idx = knn_reg_t'(r);
      case (idx)
        REG_NUM_NEIGHBOURS: val = k;
        REG_MIN_VOTES:      val = mv;
        REG_NUM_CLASSES:    val = nc;
        default:            val = CFG_W'(cm);
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      apply_reg(idx, val);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(16);
      3:       return CFG_W'($urandom_range(17, 31));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_min_votes();
    case ($urandom_range(0, 5))
      0:       return CFG_W'(0);
      1:       return CFG_W'($urandom_range(17, 31));
      2:       return CFG_W'(16);
      default: return CFG_W'($urandom_range(0, 4));
    endcase
  endfunction

  // Random neighbor word; small distance ranges make equal distances common.
  function automatic nb_word_t random_neighbour(bit close_query, bit close_eval);
    nb_word_t w;
    case ($urandom_range(0, 9))
      0:       w.distance = '1;
      1:       w.distance = {{(DIST_BITS_DEF-1){1'b1}}, 1'b0};
      2:       w.distance = '0;
      3, 4, 5: w.distance = $urandom();
      default: w.distance = dist_t'($urandom_range(0, 15));
    endcase
    if ($urandom_range(0, 3) != 0)
      w.neighbour_class = CLS_W'($urandom_range(0, active_classes() - 1));
    else
      w.neighbour_class = CLS_W'($urandom_range(0, 15));
    if ($urandom_range(0, 3) != 0)
      w.true_class = CLS_W'($urandom_range(0, active_classes() - 1));
    else
      w.true_class = CLS_W'($urandom_range(0, 15));
    w.is_self        = ($urandom_range(0, 15) == 0);
    w.last_neighbour = close_query;
    if (close_query) w.last_query = close_eval || ($urandom_range(0, 7) == 0);
    else             w.last_query = ($urandom_range(0, 15) == 0);
    return w;
  endfunction

  // Reset defaults: single neighbor, two classes, per-query results.
  task automatic test_reset_defaults();
    send_word(mk_word('0, 1, 0, 1, 0, 0));
    send_word(mk_word('1, 0, 0, 1, 0, 0));
    send_word(mk_word({{(DIST_BITS_DEF-1){1'b1}}, 1'b0}, 0, 1, 1, 0, 0));
    send_word(mk_word(dist_t'(5), 3, 0, 1, 0, 0));
  endtask

  // Full list of sixteen slots with self words, unused distances and a stray
  // last-query mark that must be ignored without the end-of-query mark.
  task automatic test_wide_query();
    set_config(CFG_W'(16), CFG_W'(0), CFG_W'(16), 1'b0);
    send_word(mk_word(dist_t'(10), 15, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(3), 15, 0, 0, 0, 0));
    send_word(mk_word({{(DIST_BITS_DEF-1){1'b1}}, 1'b0}, 0, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(7), 15, 1, 0, 0, 0));
    send_word(mk_word('0, 2, 0, 0, 0, 1));
    send_word(mk_word(dist_t'(1), 15, 0, 1, 15, 1));
    send_word(mk_word(dist_t'(1), 7, 0, 0, 0, 1));
    send_word(mk_word(dist_t'(1), 7, 1, 1, 7, 0));
  endtask

  // Out-of-range registers: k and classes clamp, min_votes cannot be met.
  task automatic test_clamped_config();
    set_config(CFG_W'(0), CFG_W'(17), CFG_W'(0), 1'b0);
    send_word(mk_word(dist_t'(4), 0, 0, 1, 0, 0));
  endtask

  // Two classes with equal votes give an undecided result.
  task automatic test_tie();
    set_config(CFG_W'(4), CFG_W'(0), CFG_W'(4), 1'b0);
    send_word(mk_word(dist_t'(9), 1, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(8), 1, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(9), 2, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(8), 2, 0, 1, 0, 0));
  endtask

  // Count mode: one matching query, one short of votes, total on the last.
  task automatic test_count_mode();
    set_config(CFG_W'(31), CFG_W'(2), CFG_W'(31), 1'b1);
    send_word(mk_word(dist_t'(3), 5, 0, 0, 0, 0));
    send_word(mk_word(dist_t'(2), 5, 0, 1, 5, 0));
    send_word(mk_word(dist_t'(1), 1, 0, 1, 1, 1));
  endtask

  // Longer count-mode evaluation without gaps; one class and no vote floor
  // make every query match, and the total restarts after the last query.
  task automatic test_count_run();
    int q;
    idle_on = 1'b0;
    set_config(CFG_W'(1), CFG_W'(0), CFG_W'(1), 1'b1);
    for (q = 0; q < COUNT_RUN_QUERIES; q++)
      send_word(mk_word($urandom(), 0, 0, 1, 0, q == COUNT_RUN_QUERIES - 1));
    send_word(mk_word($urandom(), 0, 0, 1, 0, 1));
    idle_on = 1'b1;
  endtask

  // Random phases of whole queries, each phase under a new register setting.
  task automatic test_random_queries(int n_phases, int words_per_phase);
    int ph;
    int sent;
    int q_len;
    int j;
    bit final_q;
    for (ph = 0; ph < n_phases; ph++) begin
      idle_on = (ph < n_phases - 2);
      set_config(pick_size(), pick_min_votes(), pick_size(), $urandom_range(0, 2) == 0);
      sent = 0;
      while (sent < words_per_phase) begin
        if ($urandom_range(0, 3) == 0) q_len = $urandom_range(1, 40);
        else                           q_len = $urandom_range(1, 8);
        final_q = (sent + q_len >= words_per_phase);
        for (j = 0; j < q_len; j++)
          send_word(random_neighbour(j == q_len - 1, final_q));
        sent += q_len;
      end
    end
  endtask

  // Receiver: ready with random stall bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left   <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Each result word is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    vote_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_votes.size() == 0) begin
        $error("result with no prediction pending: predicted_class %0d match_count %0d",
               $signed(out_ch.predicted_class), out_ch.match_count);
        fail_count++;
      end else begin
        want = pending_votes.pop_front();
        if (out_ch.predicted_class !== want.predicted_class) begin
          $error("predicted_class expected %0d actual %0d",
                 $signed(want.predicted_class), $signed(out_ch.predicted_class));
          fail_count++;
        end
        if (out_ch.match_count !== want.match_count) begin
          $error("match_count expected %0d actual %0d", want.match_count, out_ch.match_count);
          fail_count++;
        end
        if (out_ch.is_count !== want.is_count) begin
          $error("is_count expected %0d actual %0d", want.is_count, out_ch.is_count);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[knn_vote_classifier] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.distance        = '0;
    in_ch.neighbour_class = '0;
    in_ch.is_self         = 1'b0;
    in_ch.last_neighbour  = 1'b0;
    in_ch.true_class      = '0;
    in_ch.last_query      = 1'b0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_NUM_NEIGHBOURS;
    cfg_ch.data           = '0;
    k_cfg                 = NUM_NEIGHBOURS_RST;
    minv_cfg              = MIN_VOTES_RST;
    ncls_cfg              = NUM_CLASSES_RST;
    count_cfg             = 1'b0;
    match_total           = '0;
    clear_kept();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_wide_query();
    test_clamped_config();
    test_tie();
    test_count_mode();
    test_count_run();
    test_random_queries(12, 100);

    wait_quiet();
    if (fail_count == 0) begin
      $display("[knn_vote_classifier] OK");
    end else begin
      $display("[knn_vote_classifier] ERROR");
    end
    $finish;
  end

endmodule
